// ----- rtl/core/jsc_pkg.sv -----
`timescale 1ns / 1ps

package jsc_pkg;

    localparam int MAX_DEPTH = 32;
    localparam int LEVEL_W   = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    typedef enum logic [4:0] {
        ST_TOP, ST_END, ST_OBJ_START, ST_OBJ_COLON, ST_OBJ_VALUE, ST_OBJ_AFTER,
        ST_ARR_START, ST_ARR_AFTER, ST_STR, ST_ESC, ST_HEX1, ST_HEX2, ST_HEX3, ST_HEX4,
        ST_LIT, ST_N_SIGN, ST_N_ZERO, ST_N_INT, ST_N_DOT, ST_N_FRAC, ST_N_EXP,
        ST_N_EXPSIGN, ST_N_EXPDIG, ST_ERR
    } state_t;

    // byte classes
    localparam logic [2:0] CLS_WS     = 3'd0;
    localparam logic [2:0] CLS_STRUCT = 3'd1;
    localparam logic [2:0] CLS_KEY    = 3'd2;
    localparam logic [2:0] CLS_STR    = 3'd3;
    localparam logic [2:0] CLS_NUM    = 3'd4;
    localparam logic [2:0] CLS_LIT    = 3'd5;

    // completed value kinds
    localparam logic [3:0] KIND_NONE  = 4'd0;
    localparam logic [3:0] KIND_STR   = 4'd1;
    localparam logic [3:0] KIND_INT   = 4'd2;
    localparam logic [3:0] KIND_REAL  = 4'd3;
    localparam logic [3:0] KIND_OBJ   = 4'd4;
    localparam logic [3:0] KIND_ARR   = 4'd5;
    localparam logic [3:0] KIND_TRUE  = 4'd6;

    // error codes
    localparam logic [3:0] ERR_NONE     = 4'd0;
    localparam logic [3:0] ERR_TOP      = 4'd1;
    localparam logic [3:0] ERR_KEY      = 4'd2;
    localparam logic [3:0] ERR_COLON    = 4'd3;
    localparam logic [3:0] ERR_SEP      = 4'd4;
    localparam logic [3:0] ERR_VALUE    = 4'd5;
    localparam logic [3:0] ERR_ESC      = 4'd6;
    localparam logic [3:0] ERR_HEX      = 4'd7;
    localparam logic [3:0] ERR_LIT      = 4'd8;
    localparam logic [3:0] ERR_DIGIT    = 4'd9;
    localparam logic [3:0] ERR_OVERFLOW = 4'd10;
    localparam logic [3:0] ERR_TRAIL    = 4'd11;
    localparam logic [3:0] ERR_EOF      = 4'd12;

    // literal kinds as stored
    localparam logic [1:0] LK_NONE  = 2'd0;
    localparam logic [1:0] LK_TRUE  = 2'd1;
    localparam logic [1:0] LK_FALSE = 2'd2;
    localparam logic [1:0] LK_NULL  = 2'd3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UE     = 8'h45;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    // k: 0 true, 1 false, 2 null (3 unused)
    function automatic logic [2:0] lit_len(input logic [1:0] k);
        return (k == 2'd1) ? 3'd4 : 3'd3;
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [1:0] p);
        logic [7:0] ch;
        unique case ({k, p})
            4'b00_00: ch = CH_R;
            4'b00_01: ch = CH_U;
            4'b00_10: ch = CH_E;
            4'b01_00: ch = CH_A;
            4'b01_01: ch = CH_L;
            4'b01_10: ch = CH_S;
            4'b01_11: ch = CH_E;
            4'b10_00: ch = CH_U;
            4'b10_01: ch = CH_L;
            4'b10_10: ch = CH_L;
            default:  ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/core/jsc_stream_if.sv -----
`timescale 1ns / 1ps

interface jsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_doc;

    modport source (output valid, data_byte, end_of_doc, input ready);
    modport sink   (input valid, data_byte, end_of_doc, output ready);
endinterface

interface jsc_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] byte_class;
    logic [5:0] depth;
    logic       value_done;
    logic [3:0] value_kind;
    logic [3:0] error_code;
    logic       accepted;
    logic       last_result;

    modport source (output valid, byte_class, depth, value_done, value_kind, error_code,
                    accepted, last_result, input ready);
    modport sink   (input valid, byte_class, depth, value_done, value_kind, error_code,
                    accepted, last_result, output ready);
endinterface

// ----- rtl/core/json_syntax_checker_core.sv -----
`timescale 1ns / 1ps
// A word accepted at the input passes the input register, then the result register, and
// leaves as its result word; one word in and one word out every cycle when nothing stalls.
// Throughput is set by the combinational state update between the two registers.
// Reset (rst_n low, asynchronous) empties both registers and returns the parser to the
// top-level start; the container stack holds no reset and is only read after a push.
module json_syntax_checker_core
(
    input  logic                clk,
    input  logic                rst_n,
    jsc_byte_if.sink            bytes,
    jsc_result_if.source        results
);
    import jsc_pkg::*;

    // input register
    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           byte_reg;
    logic                 eod_reg;

    // parser state
    state_t               state_reg, state_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [MAX_DEPTH-1:0] stack_reg;
    logic [2:0]           lit_prog_reg, lit_prog_next;
    logic [1:0]           lit_kind_reg, lit_kind_next;
    logic                 real_reg, real_next;
    logic                 key_reg, key_next;
    logic [3:0]           sticky_reg, sticky_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic [2:0]           cls_reg, cls_next;
    logic [5:0]           depth_reg, depth_next;
    logic                 done_reg, done_next;
    logic [3:0]           kind_reg, kind_next;
    logic [3:0]           err_reg, err_next;
    logic                 acc_reg, acc_next;
    logic                 last_reg, last_next;

    logic                 adv;
    logic                 work;

    // per-byte transition
    state_t               step_state;
    logic [LEVEL_W-1:0]   step_level;
    logic [2:0]           step_lit_prog;
    logic [1:0]           step_lit_kind;
    logic                 step_real;
    logic                 step_key;
    logic [2:0]           step_cls;
    logic                 step_done;
    logic [3:0]           step_kind;
    logic                 step_fail;
    logic [3:0]           step_code;
    logic                 push_en;
    logic                 push_arr;

    state_t               after_cur;
    state_t               after_pop;
    logic [IDX_W-1:0]     top_idx;
    logic [IDX_W-1:0]     under_idx;
    logic [1:0]           lit_k;

    state_t               mid_state;
    logic [3:0]           mid_sticky;
    logic                 fin_fail;

    assign adv         = !out_valid_reg || results.ready;
    assign work        = in_valid_reg && adv;
    assign bytes.ready = !in_valid_reg || adv;

    assign top_idx   = IDX_W'(level_reg - LEVEL_W'(1));
    assign under_idx = IDX_W'(level_reg - LEVEL_W'(2));
    assign after_cur = (level_reg == '0) ? ST_END :
                       (stack_reg[top_idx] ? ST_ARR_AFTER : ST_OBJ_AFTER);
    assign after_pop = (level_reg <= LEVEL_W'(1)) ? ST_END :
                       (stack_reg[under_idx] ? ST_ARR_AFTER : ST_OBJ_AFTER);
    assign lit_k     = (lit_kind_reg != LK_NONE) ? 2'(lit_kind_reg - 2'd1) : 2'd0;

    always_comb
    begin
        state_t view;
        logic   num_held;
        logic   enter;
        logic   open_req;
        logic   open_arr;
        logic   close_req;
        logic   close_arr;

        step_state    = state_reg;
        step_level    = level_reg;
        step_lit_prog = lit_prog_reg;
        step_lit_kind = lit_kind_reg;
        step_real     = real_reg;
        step_key      = key_reg;
        step_cls      = CLS_WS;
        step_done     = 1'b0;
        step_kind     = KIND_NONE;
        step_fail     = 1'b0;
        step_code     = ERR_NONE;
        push_en       = 1'b0;
        push_arr      = 1'b0;
        view          = state_reg;
        num_held      = 1'b0;
        enter         = 1'b0;
        open_req      = 1'b0;
        open_arr      = 1'b0;
        close_req     = 1'b0;
        close_arr     = 1'b0;

        if (state_reg != ST_ERR)
        begin
            if (byte_reg == CH_NUL && level_reg != '0)
            begin
                step_fail = 1'b1;
                step_code = ERR_EOF;
            end
            else
            begin
                // numbers end on the delimiter, which is then parsed in the after-value state
                if (state_reg == ST_N_ZERO || state_reg == ST_N_INT ||
                    state_reg == ST_N_FRAC || state_reg == ST_N_EXPDIG)
                begin
                    if (state_reg != ST_N_ZERO && is_digit(byte_reg))
                    begin
                        step_cls = CLS_NUM;
                        num_held = 1'b1;
                    end
                    else if ((state_reg == ST_N_ZERO || state_reg == ST_N_INT) &&
                             byte_reg == CH_DOT)
                    begin
                        step_real  = 1'b1;
                        step_state = ST_N_DOT;
                        step_cls   = CLS_NUM;
                        num_held   = 1'b1;
                    end
                    else if (state_reg != ST_N_EXPDIG && (byte_reg == CH_E || byte_reg == CH_UE))
                    begin
                        step_state = ST_N_EXP;
                        step_cls   = CLS_NUM;
                        num_held   = 1'b1;
                    end
                    else
                    begin
                        step_done  = 1'b1;
                        step_kind  = real_reg ? KIND_REAL : KIND_INT;
                        step_real  = 1'b0;
                        step_state = after_cur;
                        view       = after_cur;
                    end
                end

                if (!num_held)
                begin
                    if (view <= ST_ARR_AFTER && is_ws(byte_reg))
                    begin
                        step_cls = CLS_WS;
                    end
                    else
                    begin
                        unique case (view)
                            ST_TOP:
                            begin
                                if (byte_reg == CH_LBRACE || byte_reg == CH_LBRACK)
                                begin
                                    open_req = 1'b1;
                                    open_arr = (byte_reg == CH_LBRACK);
                                end
                                else
                                begin
                                    step_fail = 1'b1;
                                    step_code = ERR_TOP;
                                end
                            end
                            ST_END:
                            begin
                                step_fail = 1'b1;
                                step_code = ERR_TRAIL;
                            end
                            ST_OBJ_START:
                            begin
                                if (byte_reg == CH_QUOTE)
                                begin
                                    step_state = ST_STR;
                                    step_key   = 1'b1;
                                    step_cls   = CLS_KEY;
                                end
                                else if (byte_reg == CH_RBRACE)
                                begin
                                    close_req = 1'b1;
                                end
                                else
                                begin
                                    step_fail = 1'b1;
                                    step_code = ERR_KEY;
                                end
                            end
                            ST_OBJ_COLON:
                            begin
                                if (byte_reg == CH_COLON)
                                begin
                                    step_state = ST_OBJ_VALUE;
                                    step_cls   = CLS_STRUCT;
                                end
                                else
                                begin
                                    step_fail = 1'b1;
                                    step_code = ERR_COLON;
                                end
                            end
                            ST_OBJ_VALUE:
                            begin
                                enter = 1'b1;
                            end
                            ST_OBJ_AFTER, ST_ARR_AFTER:
                            begin
                                if (byte_reg == CH_COMMA)
                                begin
                                    step_state = (view == ST_ARR_AFTER) ? ST_ARR_START
                                                                         : ST_OBJ_START;
                                    step_cls   = CLS_STRUCT;
                                end
                                else if (view == ST_OBJ_AFTER && byte_reg == CH_RBRACE)
                                begin
                                    close_req = 1'b1;
                                end
                                else if (view == ST_ARR_AFTER && byte_reg == CH_RBRACK)
                                begin
                                    close_req = 1'b1;
                                    close_arr = 1'b1;
                                end
                                else
                                begin
                                    step_fail = 1'b1;
                                    step_code = ERR_SEP;
                                end
                            end
                            ST_ARR_START:
                            begin
                                if (byte_reg == CH_RBRACK)
                                begin
                                    close_req = 1'b1;
                                    close_arr = 1'b1;
                                end
                                else
                                begin
                                    enter = 1'b1;
                                end
                            end
                            ST_STR:
                            begin
                                step_cls = key_reg ? CLS_KEY : CLS_STR;
                                if (byte_reg == CH_QUOTE)
                                begin
                                    if (key_reg)
                                    begin
                                        step_key   = 1'b0;
                                        step_state = ST_OBJ_COLON;
                                    end
                                    else
                                    begin
                                        step_done  = 1'b1;
                                        step_kind  = KIND_STR;
                                        step_state = after_cur;
                                    end
                                end
                                else if (byte_reg == CH_BSLASH)
                                begin
                                    step_state = ST_ESC;
                                end
                            end
                            ST_ESC:
                            begin
                                step_cls = key_reg ? CLS_KEY : CLS_STR;
                                if (byte_reg == CH_QUOTE || byte_reg == CH_BSLASH ||
                                    byte_reg == CH_SLASH || byte_reg == CH_B ||
                                    byte_reg == CH_F || byte_reg == CH_N ||
                                    byte_reg == CH_R || byte_reg == CH_T)
                                begin
                                    step_state = ST_STR;
                                end
                                else if (byte_reg == CH_U)
                                begin
                                    step_state = ST_HEX1;
                                end
                                else
                                begin
                                    step_fail = 1'b1;
                                    step_code = ERR_ESC;
                                end
                            end
                            ST_HEX1, ST_HEX2, ST_HEX3, ST_HEX4:
                            begin
                                step_cls = key_reg ? CLS_KEY : CLS_STR;
                                if (is_hex(byte_reg))
                                begin
                                    step_state = (view == ST_HEX4) ? ST_STR : state_t'(view + 5'd1);
                                end
                                else
                                begin
                                    step_fail = 1'b1;
                                    step_code = ERR_HEX;
                                end
                            end
                            ST_LIT:
                            begin
                                step_cls = CLS_LIT;
                                if (lit_prog_reg < lit_len(lit_k) &&
                                    byte_reg == lit_char(lit_k, lit_prog_reg[1:0]))
                                begin
                                    step_lit_prog = lit_prog_reg + 3'd1;
                                    if (lit_prog_reg + 3'd1 == lit_len(lit_k))
                                    begin
                                        step_done     = 1'b1;
                                        step_kind     = KIND_TRUE + 4'(lit_k);
                                        step_lit_prog = 3'd0;
                                        step_lit_kind = LK_NONE;
                                        step_state    = after_cur;
                                    end
                                end
                                else
                                begin
                                    step_fail = 1'b1;
                                    step_code = ERR_LIT;
                                end
                            end
                            ST_N_SIGN:
                            begin
                                step_cls = CLS_NUM;
                                if (byte_reg == CH_ZERO)
                                begin
                                    step_state = ST_N_ZERO;
                                end
                                else if (is_digit(byte_reg))
                                begin
                                    step_state = ST_N_INT;
                                end
                                else
                                begin
                                    step_fail = 1'b1;
                                    step_code = ERR_DIGIT;
                                end
                            end
                            ST_N_DOT, ST_N_EXPSIGN:
                            begin
                                step_cls = CLS_NUM;
                                if (is_digit(byte_reg))
                                begin
                                    step_state = (view == ST_N_DOT) ? ST_N_FRAC : ST_N_EXPDIG;
                                end
                                else
                                begin
                                    step_fail = 1'b1;
                                    step_code = ERR_DIGIT;
                                end
                            end
                            ST_N_EXP:
                            begin
                                step_cls = CLS_NUM;
                                if (byte_reg == CH_PLUS || byte_reg == CH_MINUS)
                                begin
                                    step_state = ST_N_EXPSIGN;
                                end
                                else if (is_digit(byte_reg))
                                begin
                                    step_state = ST_N_EXPDIG;
                                end
                                else
                                begin
                                    step_fail = 1'b1;
                                    step_code = ERR_DIGIT;
                                end
                            end
                            default:
                            begin
                                step_cls = CLS_WS;
                            end
                        endcase

                        if (enter)
                        begin
                            if (byte_reg == CH_QUOTE)
                            begin
                                step_state = ST_STR;
                                step_key   = 1'b0;
                                step_cls   = CLS_STR;
                            end
                            else if (byte_reg == CH_MINUS)
                            begin
                                step_state = ST_N_SIGN;
                                step_real  = 1'b0;
                                step_cls   = CLS_NUM;
                            end
                            else if (byte_reg == CH_ZERO)
                            begin
                                step_state = ST_N_ZERO;
                                step_real  = 1'b0;
                                step_cls   = CLS_NUM;
                            end
                            else if (is_digit(byte_reg))
                            begin
                                step_state = ST_N_INT;
                                step_real  = 1'b0;
                                step_cls   = CLS_NUM;
                            end
                            else if (byte_reg == CH_LBRACE || byte_reg == CH_LBRACK)
                            begin
                                open_req = 1'b1;
                                open_arr = (byte_reg == CH_LBRACK);
                            end
                            else if (byte_reg == CH_T || byte_reg == CH_F || byte_reg == CH_N)
                            begin
                                step_lit_kind = (byte_reg == CH_T) ? LK_TRUE :
                                                (byte_reg == CH_F) ? LK_FALSE : LK_NULL;
                                step_lit_prog = 3'd0;
                                step_state    = ST_LIT;
                                step_cls      = CLS_LIT;
                            end
                            else
                            begin
                                step_fail = 1'b1;
                                step_code = ERR_VALUE;
                            end
                        end

                        if (open_req)
                        begin
                            if (level_reg >= LEVEL_W'(MAX_DEPTH))
                            begin
                                step_fail = 1'b1;
                                step_code = ERR_OVERFLOW;
                            end
                            else
                            begin
                                push_en    = 1'b1;
                                push_arr   = open_arr;
                                step_level = level_reg + LEVEL_W'(1);
                                step_state = open_arr ? ST_ARR_START : ST_OBJ_START;
                                step_cls   = CLS_STRUCT;
                            end
                        end

                        if (close_req)
                        begin
                            if (level_reg != '0)
                            begin
                                step_level = level_reg - LEVEL_W'(1);
                            end
                            step_cls   = CLS_STRUCT;
                            step_done  = 1'b1;
                            step_kind  = close_arr ? KIND_ARR : KIND_OBJ;
                            step_state = after_pop;
                        end
                    end
                end
            end
        end

        if (step_fail)
        begin
            step_cls  = CLS_WS;
            step_done = 1'b0;
            step_kind = KIND_NONE;
        end
    end

    // end-of-document check on top of the byte's own transition
    always_comb
    begin
        mid_state  = step_fail ? ST_ERR : step_state;
        mid_sticky = (step_fail && sticky_reg == ERR_NONE) ? step_code : sticky_reg;
        fin_fail   = eod_reg && mid_sticky == ERR_NONE && mid_state != ST_END;
    end

    // next state
    always_comb
    begin
        in_valid_next  = bytes.ready ? bytes.valid : in_valid_reg;
        out_valid_next = adv ? in_valid_reg : out_valid_reg;
        state_next     = state_reg;
        level_next     = level_reg;
        lit_prog_next  = lit_prog_reg;
        lit_kind_next  = lit_kind_reg;
        real_next      = real_reg;
        key_next       = key_reg;
        sticky_next    = sticky_reg;
        if (work)
        begin
            if (eod_reg)
            begin
                state_next    = ST_TOP;
                level_next    = '0;
                lit_prog_next = 3'd0;
                lit_kind_next = LK_NONE;
                real_next     = 1'b0;
                key_next      = 1'b0;
                sticky_next   = ERR_NONE;
            end
            else
            begin
                state_next    = mid_state;
                level_next    = step_level;
                lit_prog_next = step_lit_prog;
                lit_kind_next = step_lit_kind;
                real_next     = step_real;
                key_next      = step_key;
                sticky_next   = mid_sticky;
            end
        end
    end

    // result word
    always_comb
    begin
        cls_next   = fin_fail ? CLS_WS : step_cls;
        done_next  = fin_fail ? 1'b0 : step_done;
        kind_next  = fin_fail ? KIND_NONE : step_kind;
        depth_next = 6'(step_level);
        err_next   = fin_fail ? ERR_EOF : mid_sticky;
        acc_next   = eod_reg && mid_sticky == ERR_NONE && mid_state == ST_END;
        last_next  = eod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_TOP;
            level_reg     <= '0;
            lit_prog_reg  <= 3'd0;
            lit_kind_reg  <= LK_NONE;
            real_reg      <= 1'b0;
            key_reg       <= 1'b0;
            sticky_reg    <= ERR_NONE;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            level_reg     <= level_next;
            lit_prog_reg  <= lit_prog_next;
            lit_kind_reg  <= lit_kind_next;
            real_reg      <= real_next;
            key_reg       <= key_next;
            sticky_reg    <= sticky_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.ready && bytes.valid)
        begin
            byte_reg <= bytes.data_byte;
            eod_reg  <= bytes.end_of_doc;
        end
        if (work && push_en)
        begin
            stack_reg[level_reg[IDX_W-1:0]] <= push_arr;
        end
        if (work)
        begin
            cls_reg   <= cls_next;
            depth_reg <= depth_next;
            done_reg  <= done_next;
            kind_reg  <= kind_next;
            err_reg   <= err_next;
            acc_reg   <= acc_next;
            last_reg  <= last_next;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.byte_class  = cls_reg;
    assign results.depth       = depth_reg;
    assign results.value_done  = done_reg;
    assign results.value_kind  = kind_reg;
    assign results.error_code  = err_reg;
    assign results.accepted    = acc_reg;
    assign results.last_result = last_reg;

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LEVEL_W'(MAX_DEPTH))
        else $error("stack level beyond maximum depth");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ERR |-> sticky_reg != ERR_NONE)
        else $error("error state without recorded error code");

    a_doc_restart: assert property (@(posedge clk) disable iff (!rst_n)
        work && eod_reg |=> state_reg == ST_TOP && level_reg == '0 && sticky_reg == ERR_NONE)
        else $error("parser not restarted after final word");

    a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && acc_reg |-> last_reg && err_reg == ERR_NONE)
        else $error("acceptance on a non-final or failed word");

    a_kind_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !done_reg |-> kind_reg == KIND_NONE)
        else $error("value kind without completed value");

endmodule
